// ----- src/assert_macros.svh -----
// assertion macros used by the rtl file pad_cordic.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ----- src/pad_pkg.sv -----
// types, constants and the arctangent table of the plane angle block
package pad_pkg;

	// field widths
	localparam int CW     = 16;          // component width
	localparam int CS     = 16;          // cordic micro-rotations
	localparam int FUNC_W = 2;
	localparam int RES_W  = 17;          // Q9.8 angle
	localparam int AW     = CW + 1;      // operand after half-plane fold
	localparam int XW     = CW + CS + 3; // cordic datapath width
	localparam int ACC_W  = 27;          // angle accumulator, Q.16 degrees
	localparam int RQ_W   = ACC_W - 8;   // accumulator after rounding to Q.8

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// plane select codes
	localparam logic [FUNC_W-1:0] SEL_XY = 2'd0;
	localparam logic [FUNC_W-1:0] SEL_YZ = 2'd1;
	localparam logic [FUNC_W-1:0] SEL_XZ = 2'd2;

	// angle constants
	localparam logic signed [ACC_W-1:0] DEG180_Q16 = ACC_W'(180 * 65536);
	localparam logic signed [ACC_W-1:0] DEG360_Q16 = ACC_W'(360 * 65536);
	localparam logic [ACC_W-1:0]        HALF_LSB_Q8 = ACC_W'(128);
	localparam logic [RQ_W-1:0]         DEG360_RQ  = RQ_W'(360 * 256);
	localparam logic [RES_W-1:0]        DEG360_Q8  = RES_W'(360 * 256);
	localparam logic [RES_W-1:0]        DEG180_Q8  = RES_W'(180 * 256);

	// classified word handed from front to back
	typedef struct packed {
		logic                 spec; // angle known without rotation
		logic                 neg;  // folded by 180 degrees
		logic signed [AW-1:0] a;    // first component
		logic signed [AW-1:0] b;    // second component
	} pad_work_t;

	// atan(2^-i) in degrees, Q.16, rounded to nearest
	function automatic logic signed [ACC_W-1:0] atan_q16(input int unsigned idx);
		logic signed [ACC_W-1:0] v;
		case (idx)
			0:       v = ACC_W'(2949120);
			1:       v = ACC_W'(1740967);
			2:       v = ACC_W'(919879);
			3:       v = ACC_W'(466945);
			4:       v = ACC_W'(234379);
			5:       v = ACC_W'(117304);
			6:       v = ACC_W'(58666);
			7:       v = ACC_W'(29335);
			8:       v = ACC_W'(14668);
			9:       v = ACC_W'(7334);
			10:      v = ACC_W'(3667);
			11:      v = ACC_W'(1833);
			12:      v = ACC_W'(917);
			13:      v = ACC_W'(458);
			14:      v = ACC_W'(229);
			15:      v = ACC_W'(115);
			16:      v = ACC_W'(57);
			17:      v = ACC_W'(29);
			18:      v = ACC_W'(14);
			19:      v = ACC_W'(7);
			20:      v = ACC_W'(4);
			21:      v = ACC_W'(2);
			22:      v = ACC_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/pad_if.sv -----
// valid/ready channel interfaces for vector words and angle words
interface pad_in_if import pad_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic signed [CW-1:0] comp_x;
	logic signed [CW-1:0] comp_y;
	logic signed [CW-1:0] comp_z;

	modport source (output valid, func, comp_x, comp_y, comp_z, input ready);
	modport sink (input valid, func, comp_x, comp_y, comp_z, output ready);
endinterface

interface pad_out_if import pad_pkg::*;;
	logic             valid;
	logic             ready;
	logic [RES_W-1:0] angle_deg;

	modport source (output valid, angle_deg, input ready);
	modport sink (input valid, angle_deg, output ready);
endinterface

// ----- src/pad_front.sv -----
// front end: accepts vectors, picks the component pair and folds to the right half plane
module pad_front import pad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pad_in_if.sink    vec,
	output logic      w_vld,
	output pad_work_t w_word,
	input  logic      w_rdy
);

	logic                 f_vld_q;
	pad_work_t            f_word_q;
	pad_work_t            cls;
	logic signed [AW-1:0] xe, ye, ze, ra, rb;
	logic                 bad_sel;

	// accept when the holding register is empty or draining
	assign vec.ready = !f_vld_q || w_rdy;
	assign w_vld     = f_vld_q;
	assign w_word    = f_word_q;

	// pair selection and half-plane fold
	always_comb begin
		xe      = {vec.comp_x[CW-1], vec.comp_x};
		ye      = {vec.comp_y[CW-1], vec.comp_y};
		ze      = {vec.comp_z[CW-1], vec.comp_z};
		ra      = xe;
		rb      = ye;
		bad_sel = 1'b0;
		case (vec.func)
			SEL_XY: begin
				ra = xe;
				rb = ye;
			end
			SEL_YZ: begin
				// y of zero falls back to the xz pair
				ra = (vec.comp_y != '0) ? ye : xe;
				rb = ze;
			end
			SEL_XZ: begin
				ra = xe;
				rb = ze;
			end
			default: begin
				bad_sel = 1'b1;
			end
		endcase
		cls.spec = bad_sel || (rb == '0);
		cls.neg  = !bad_sel && ra[AW-1];
		cls.a    = cls.neg ? -ra : ra;
		cls.b    = cls.neg ? -rb : rb;
	end

	// holding register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_vld_q <= 1'b0;
		end else if (vec.ready) begin
			f_vld_q <= vec.valid;
		end
	end

	// holding register payload
	always_ff @(posedge clk) begin
		if (vec.ready && vec.valid) begin
			f_word_q <= cls;
		end
	end

endmodule

// ----- src/pad_fifo.sv -----
// short queue of classified words between front and back
module pad_fifo import pad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_vld,
	input  pad_work_t push_word,
	output logic      push_rdy,
	output logic      pop_vld,
	output pad_work_t pop_word,
	input  logic      pop_rdy
);

	pad_work_t            mem_q [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0]   wr_q, rd_q;
	logic [FIFO_AW:0]     cnt_q;
	logic                 do_push, do_pop;

	assign push_rdy = (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH));
	assign pop_vld  = (cnt_q != '0);
	assign pop_word = mem_q[rd_q];
	assign do_push  = push_vld && push_rdy;
	assign do_pop   = pop_vld && pop_rdy;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_word;
		end
	end

endmodule

// ----- src/pad_cordic.sv -----
// back end: pipelined vectoring cordic, angle fold and rounding, output register
`include "assert_macros.svh"

module pad_cordic import pad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      w_vld,
	input  pad_work_t w_word,
	output logic      w_rdy,
	pad_out_if.source res
);

	// stage registers, index k holds the state after k micro-rotations
	logic                    vld_s  [1:CS];
	logic                    spec_s [1:CS];
	logic                    neg_s  [1:CS];
	logic signed [ACC_W-1:0] acc_s  [1:CS];
	logic signed [XW-1:0]    x_s    [1:CS-1];
	logic signed [XW-1:0]    y_s    [1:CS-1];

	// per-rotation inputs and results
	logic signed [XW-1:0]    xi     [0:CS-2];
	logic signed [XW-1:0]    yi     [0:CS-1];
	logic signed [ACC_W-1:0] ai     [0:CS-1];
	logic signed [XW-1:0]    nx_x   [0:CS-2];
	logic signed [XW-1:0]    nx_y   [0:CS-2];
	logic signed [ACC_W-1:0] nx_acc [0:CS-1];

	logic signed [XW-1:0]    x0, y0;
	logic signed [ACC_W-1:0] acc0;
	logic                    adv;
	logic                    res_vld_q;
	logic [RES_W-1:0]        res_q;
	logic signed [ACC_W-1:0] acc_f;
	logic [ACC_W-1:0]        rnd;
	logic [RQ_W-1:0]         rq, rq_w;
	logic [RES_W-1:0]        res_d;

	// whole pipe moves unless the output word is stuck
	assign adv       = !res_vld_q || res.ready;
	assign w_rdy     = adv;
	assign res.valid = res_vld_q;
	assign res.angle_deg = res_q;

	// scale operands up by the rotation count
	assign x0   = {{(XW-AW-CS){w_word.a[AW-1]}}, w_word.a, {CS{1'b0}}};
	assign y0   = {{(XW-AW-CS){w_word.b[AW-1]}}, w_word.b, {CS{1'b0}}};
	assign acc0 = w_word.neg ? DEG180_Q16 : '0;

	// micro-rotations, driven by the sign of y
	for (genvar k = 0; k < CS; k++) begin : g_rot
		if (k == 0) begin : g_first
			assign yi[k] = y0;
			assign ai[k] = acc0;
		end else begin : g_next
			assign yi[k] = y_s[k];
			assign ai[k] = acc_s[k];
		end
		assign nx_acc[k] = yi[k][XW-1] ? ai[k] - atan_q16(k) : ai[k] + atan_q16(k);
		if (k < CS-1) begin : g_xy
			if (k == 0) begin : g_x_first
				assign xi[k] = x0;
			end else begin : g_x_next
				assign xi[k] = x_s[k];
			end
			assign nx_x[k] = yi[k][XW-1] ? xi[k] - (yi[k] >>> k) : xi[k] + (yi[k] >>> k);
			assign nx_y[k] = yi[k][XW-1] ? yi[k] + (xi[k] >>> k) : yi[k] - (xi[k] >>> k);
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= CS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= w_vld;
			for (int k = 2; k <= CS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			spec_s[1] <= w_word.spec;
			neg_s[1]  <= w_word.neg;
			for (int k = 2; k <= CS; k++) begin
				spec_s[k] <= spec_s[k-1];
				neg_s[k]  <= neg_s[k-1];
			end
			for (int k = 1; k <= CS; k++) begin
				acc_s[k] <= nx_acc[k-1];
			end
			for (int k = 1; k < CS; k++) begin
				x_s[k] <= nx_x[k-1];
				y_s[k] <= nx_y[k-1];
			end
		end
	end

	// fold into 0..360 and round to Q.8, or pick 0 or 180 for a spec word
	always_comb begin
		acc_f = acc_s[CS][ACC_W-1] ? acc_s[CS] + DEG360_Q16 : acc_s[CS];
		rnd   = ACC_W'(acc_f) + HALF_LSB_Q8;
		rq    = rnd[ACC_W-1:8];
		rq_w  = (rq >= DEG360_RQ) ? rq - DEG360_RQ : rq;
		if (spec_s[CS]) begin
			res_d = neg_s[CS] ? DEG180_Q8 : '0;
		end else begin
			res_d = rq_w[RES_W-1:0];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= vld_s[CS];
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	`ASSERT_ALWAYS(a_res_range, !res_vld_q || (res_q < DEG360_Q8), "angle word at or above 360")
	`ASSERT_NEXT(a_spec_value, adv && vld_s[CS] && spec_s[CS], (res_q == '0) || (res_q == DEG180_Q8), "axis case gave a value other than 0 or 180")
	`ASSERT_NEXT(a_load, adv && w_vld, vld_s[1], "queued word not taken into the first stage")

endmodule

// ----- src/plane_angle_degrees_top.sv -----
// Plane angle block: one 3D vector in, one angle in degrees out.
// Channel vec carries func (0 XY, 1 YZ, 2 XZ) and signed comp_x, comp_y,
// comp_z; channel res carries angle_deg, unsigned Q9.8 in 0 up to below 360.
// Both channels move a word at a rising edge with valid and ready high.
// The angle is atan2 of the selected pair; YZ with y zero gives the XZ angle,
// a zero projection gives 0 and the unused select code gives 0.
// A front register classifies the word and folds it to the right half plane,
// a four-word queue decouples it from the back end, a 16-stage vectoring
// CORDIC (one micro-rotation per stage) and a rounding stage follow.
// Throughput is one word per cycle while res is not stalled, set by the one-rotation-per-stage pipe.
// When res is stalled the whole CORDIC pipe holds; the queue and the front
// register keep accepting until they fill, then vec.ready drops.
// Reset clears all valids; vec.ready is high as soon as reset is released.
module plane_angle_degrees_top import pad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pad_in_if.sink    vec,
	pad_out_if.source res
);

	logic      f_vld, f_rdy;
	pad_work_t f_word;
	logic      q_vld, q_rdy;
	pad_work_t q_word;

	// classify and fold
	pad_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec),
		.w_vld  (f_vld),
		.w_word (f_word),
		.w_rdy  (f_rdy)
	);

	// decoupling queue
	pad_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_vld  (f_vld),
		.push_word (f_word),
		.push_rdy  (f_rdy),
		.pop_vld   (q_vld),
		.pop_word  (q_word),
		.pop_rdy   (q_rdy)
	);

	// rotation pipe and output
	pad_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.w_vld  (q_vld),
		.w_word (q_word),
		.w_rdy  (q_rdy),
		.res    (res)
	);

endmodule
